// ===== sv/apid_pkg.sv =====
// Shared types and constants for the angle PID controller.
`timescale 1ns / 1ps
`default_nettype none

package apid_pkg;

  // Datapath widths
  localparam int DataW   = 16;  // Q8.8 samples, gains and setpoint
  localparam int ErrW    = 17;  // full-range angle error
  localparam int ProdPW  = 33;  // gain_p * error
  localparam int ProdW   = 32;  // gain_i * integral, rate * gain_d
  localparam int QuotW   = 29;  // |rate * gain_d| / 10
  localparam int SumW    = 35;  // Q16.16 accumulator
  localparam int ScaledW = 19;  // accumulator scaled to integer duty units
  localparam int DriveW  = 15;  // clamped drive output

  // Limits
  localparam logic signed [17:0] IntegLimit = 18'sd25600;  // +/-100.0 in Q8.8
  localparam logic signed [ScaledW-1:0] DriveLimit = 19'sd9000;

  // Division by ten: (n * Recip10) >> RecipShift is exact for any 32-bit n
  localparam logic [31:0] Recip10    = 32'hCCCC_CCCD;
  localparam int          RecipShift = 35;

  // Truncation toward zero when dropping the 16 fraction bits
  localparam logic [SumW-1:0] FracRound = 35'd65535;

  // Configuration register indexes
  localparam logic [1:0] REG_SETPOINT = 2'd0;
  localparam logic [1:0] REG_GAIN_P   = 2'd1;
  localparam logic [1:0] REG_GAIN_I   = 2'd2;
  localparam logic [1:0] REG_GAIN_D   = 2'd3;

  // Load enables, one per pipeline stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

`default_nettype wire

// ===== sv/apid_integ.sv =====
// Input stage: angle error, clamped integral and the stored error sum.
`timescale 1ns / 1ps
`default_nettype none

module apid_integ (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic                                  load,
  input  logic signed [apid_pkg::DataW-1:0]     measured_angle,
  input  logic signed [apid_pkg::DataW-1:0]     rate_sample,
  input  logic signed [apid_pkg::DataW-1:0]     setpoint_angle,
  output logic signed [apid_pkg::ErrW-1:0]      err,
  output logic signed [apid_pkg::DataW-1:0]     integ,
  output logic signed [apid_pkg::DataW-1:0]     rate
);

  logic signed [apid_pkg::DataW-1:0] error_sum;
  logic signed [apid_pkg::DataW-1:0] error_sum_next;
  logic signed [apid_pkg::ErrW-1:0]  err_c;
  logic signed [17:0]                sum_c;

  // Error and raw integral, both at full width
  assign err_c = {measured_angle[15], measured_angle} - {setpoint_angle[15], setpoint_angle};
  assign sum_c = {{2{error_sum[15]}}, error_sum} + {err_c[16], err_c};

  // Integral clamp to +/-100.0
  always_comb begin
    priority if (sum_c <= -apid_pkg::IntegLimit) begin
      error_sum_next = -apid_pkg::IntegLimit[15:0];
    end else if (sum_c >= apid_pkg::IntegLimit) begin
      error_sum_next = apid_pkg::IntegLimit[15:0];
    end else begin
      error_sum_next = sum_c[15:0];
    end
  end

  // Integral state moves only on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum <= '0;
    end else if (accept) begin
      error_sum <= error_sum_next;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (load) begin
      err   <= err_c;
      integ <= error_sum_next;
      rate  <= rate_sample;
    end
  end

endmodule

`default_nettype wire

// ===== sv/apid_mac.sv =====
// Gain products, rate term divided by ten and the Q16.16 sum (stages 2 to 4).
`timescale 1ns / 1ps
`default_nettype none

module apid_mac (
  input  logic                                  clk,
  input  apid_pkg::stage_en_t                   en,
  input  logic signed [apid_pkg::ErrW-1:0]      err,
  input  logic signed [apid_pkg::DataW-1:0]     integ,
  input  logic signed [apid_pkg::DataW-1:0]     rate,
  input  logic signed [apid_pkg::DataW-1:0]     gain_p,
  input  logic signed [apid_pkg::DataW-1:0]     gain_i,
  input  logic signed [apid_pkg::DataW-1:0]     gain_d,
  output logic signed [apid_pkg::SumW-1:0]      acc
);

  // Stage 2 registers
  logic signed [apid_pkg::ProdPW-1:0] prod_p2;
  logic signed [apid_pkg::ProdW-1:0]  prod_i2;
  logic signed [apid_pkg::ProdW-1:0]  prod_d2;
  // Stage 3 registers
  logic signed [apid_pkg::ProdPW-1:0] prod_p3;
  logic signed [apid_pkg::ProdW-1:0]  prod_i3;
  logic [apid_pkg::QuotW-1:0]         quot3;
  logic                               neg3;

  logic signed [apid_pkg::ProdPW-1:0] gp_ext, err_ext;
  logic signed [apid_pkg::ProdW-1:0]  gi_ext, integ_ext, gd_ext, rate_ext;
  logic [apid_pkg::ProdW-1:0]         prod_d_abs;
  logic [63:0]                        recip_prod;
  logic [apid_pkg::SumW-1:0]          quot_ext;
  logic signed [apid_pkg::SumW-1:0]   rate_term;
  logic signed [apid_pkg::SumW-1:0]   acc_c;

  // Stage 2: three independent multipliers
  assign gp_ext    = {{17{gain_p[15]}}, gain_p};
  assign err_ext   = {{16{err[16]}}, err};
  assign gi_ext    = {{16{gain_i[15]}}, gain_i};
  assign integ_ext = {{16{integ[15]}}, integ};
  assign gd_ext    = {{16{gain_d[15]}}, gain_d};
  assign rate_ext  = {{16{rate[15]}}, rate};

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_p2 <= gp_ext * err_ext;
      prod_i2 <= gi_ext * integ_ext;
      prod_d2 <= rate_ext * gd_ext;
    end
  end

  // Stage 3: magnitude of the rate product divided by ten via reciprocal
  assign prod_d_abs = prod_d2[31] ? (32'd0 - prod_d2) : prod_d2;
  assign recip_prod = 64'(prod_d_abs) * 64'(apid_pkg::Recip10);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      prod_p3 <= prod_p2;
      prod_i3 <= prod_i2;
      quot3   <= recip_prod[63:apid_pkg::RecipShift];
      neg3    <= prod_d2[31];
    end
  end

  // Stage 4: restore the sign (truncation toward zero) and sum the terms
  assign quot_ext  = {6'd0, quot3};
  assign rate_term = neg3 ? (35'd0 - quot_ext) : quot_ext;
  assign acc_c     = {{2{prod_p3[32]}}, prod_p3} + {{3{prod_i3[31]}}, prod_i3} + rate_term;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      acc <= acc_c;
    end
  end

endmodule

`default_nettype wire

// ===== sv/apid_out.sv =====
// Output stage: Q16.16 to integer, drive clamp and the result register.
`timescale 1ns / 1ps
`default_nettype none

module apid_out (
  input  logic                                  clk,
  input  logic                                  load,
  input  logic signed [apid_pkg::SumW-1:0]      acc,
  output logic signed [apid_pkg::DriveW-1:0]    drive_value,
  output logic                                  drive_clamped
);

  logic [apid_pkg::SumW-1:0]           biased;
  logic signed [apid_pkg::ScaledW-1:0] scaled;
  logic signed [apid_pkg::DriveW-1:0]  drive_c;
  logic                                clamp_c;

  // Negative sums are biased so the shift truncates toward zero
  assign biased = acc + (acc[apid_pkg::SumW-1] ? apid_pkg::FracRound : '0);
  assign scaled = biased[apid_pkg::SumW-1:16];

  // Drive clamp; exactly +/-9000 does not count as clamped
  always_comb begin
    priority if (scaled > apid_pkg::DriveLimit) begin
      drive_c = apid_pkg::DriveLimit[apid_pkg::DriveW-1:0];
      clamp_c = 1'b1;
    end else if (scaled < -apid_pkg::DriveLimit) begin
      drive_c = -apid_pkg::DriveLimit[apid_pkg::DriveW-1:0];
      clamp_c = 1'b1;
    end else begin
      drive_c = scaled[apid_pkg::DriveW-1:0];
      clamp_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_value   <= drive_c;
      drive_clamped <= clamp_c;
    end
  end

endmodule

`default_nettype wire

// ===== sv/angle_pid_saturating_top.sv =====
// Top level of the angle PID controller with integral and output clamps.
`timescale 1ns / 1ps
`default_nettype none

// Angle PID controller. Each input transaction carries one sample (measured
// angle and gyro rate, signed Q8.8) and yields exactly one result: the drive
// value kp*error + ki*integral + kd*rate/10, truncated to integer and clamped
// to +/-9000, with a flag when that clamp acted. The integral is updated at
// acceptance and held to +/-100.0. The block takes one sample per clock while
// in_ready is high, which holds unless a stalled output fills the pipeline; the
// rate is set by the integral update, while the five-stage pipeline (error and
// integral, gain multipliers, reciprocal divide by ten, sum, scale and clamp)
// sets the latency. Stages with no valid data fill while the output waits, so
// up to five samples can be in flight under backpressure. Configuration
// registers (setpoint, kp, ki, kd) are read directly by the pipeline and must
// be written only while no sample is in flight.
module angle_pid_saturating_top (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  // input samples
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  measured_angle,
  input  logic signed [15:0]  rate_sample,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [14:0]  drive_value,
  output logic                drive_clamped
);

  logic signed [15:0] setpoint_angle;
  logic signed [15:0] gain_p;
  logic signed [15:0] gain_i;
  logic signed [15:0] gain_d;

  logic [4:0]          vld;     // stage valid bits, [0] is stage 1
  apid_pkg::stage_en_t en;

  logic signed [apid_pkg::ErrW-1:0]  err1;
  logic signed [apid_pkg::DataW-1:0] integ1;
  logic signed [apid_pkg::DataW-1:0] rate1;
  logic signed [apid_pkg::SumW-1:0]  acc4;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_angle <= '0;
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apid_pkg::REG_SETPOINT: setpoint_angle <= cfg_data;
        apid_pkg::REG_GAIN_P:   gain_p         <= cfg_data;
        apid_pkg::REG_GAIN_I:   gain_i         <= cfg_data;
        apid_pkg::REG_GAIN_D:   gain_d         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage advance: a stage loads when empty or when the next one loads
  assign en.s5 = !vld[4] || out_ready;
  assign en.s4 = !vld[3] || en.s5;
  assign en.s3 = !vld[2] || en.s4;
  assign en.s2 = !vld[1] || en.s3;
  assign en.s1 = !vld[0] || en.s2;

  assign in_ready  = en.s1;
  assign out_valid = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en.s1) vld[0] <= in_valid;
      if (en.s2) vld[1] <= vld[0];
      if (en.s3) vld[2] <= vld[1];
      if (en.s4) vld[3] <= vld[2];
      if (en.s5) vld[4] <= vld[3];
    end
  end

  apid_integ u_integ (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_valid && in_ready),
    .load           (en.s1),
    .measured_angle (measured_angle),
    .rate_sample    (rate_sample),
    .setpoint_angle (setpoint_angle),
    .err            (err1),
    .integ          (integ1),
    .rate           (rate1)
  );

  apid_mac u_mac (
    .clk    (clk),
    .en     (en),
    .err    (err1),
    .integ  (integ1),
    .rate   (rate1),
    .gain_p (gain_p),
    .gain_i (gain_i),
    .gain_d (gain_d),
    .acc    (acc4)
  );

  apid_out u_out (
    .clk           (clk),
    .load          (en.s5),
    .acc           (acc4),
    .drive_value   (drive_value),
    .drive_clamped (drive_clamped)
  );

endmodule

`default_nettype wire

// ===== sv/apid_checker.sv =====
// Port-level checker for the angle PID controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module apid_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [14:0]  drive_value,
  input logic                drive_clamped
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(drive_value) && $stable(drive_clamped))
    else $error("result payload changed while stalled");

  // The clamp flag only comes with a value at the limit
  a_clamp_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_clamped |-> (drive_value == 15'sd9000) || (drive_value == -15'sd9000))
    else $error("clamp flag with a value off the limit");

  // Every delivered value is inside the drive range
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_value <= 15'sd9000) && (drive_value >= -15'sd9000))
    else $error("drive value out of range");

  // No result can be ready right after reset, and the pipeline starts empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind angle_pid_saturating_top apid_checker u_apid_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .drive_value   (drive_value),
  .drive_clamped (drive_clamped)
);

`default_nettype wire

// ===== dv/angle_pid_saturating_top_test.sv =====
// Self-checking testbench for the angle PID controller with integral and output clamps.
`timescale 1ns / 1ps

module angle_pid_saturating_top_test;

  localparam int IntegBound  = 25600;   // +/-100.0 in Q8.8
  localparam int DriveBound  = 9000;
  localparam int RateDivisor = 10;
  localparam longint Q16One  = 65536;
  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 12;      // pipeline is five deep
  localparam int ItemsPerSet = 125;
  localparam int HoldCycles  = 80;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] rate;
  } sample_t;

  typedef struct packed {
    logic signed [14:0] drive;
    logic               clamped;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = apid_pkg::REG_SETPOINT;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] measured_angle = '0;
  logic signed [15:0] rate_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [14:0] drive_value;
  logic               drive_clamped;

  angle_pid_saturating_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .measured_angle (measured_angle),
    .rate_sample    (rate_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drive_value    (drive_value),
    .drive_clamped  (drive_clamped)
  );

  always #10 clk = ~clk;

  // Controller state as the testbench sees it
  int setpoint_copy = 0;
  int kp_copy       = 0;
  int ki_copy       = 0;
  int kd_copy       = 0;
  int integral_copy = 0;

  sample_t       pending_samples[$];
  drive_result_t expected_drives[$];
  int            mismatches   = 0;
  int            results_seen = 0;
  int            cycle_count  = 0;

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Integral update, then kp*e + ki*i + kd*rate/10 in Q16.16, truncate, clamp
  task automatic predict_drive(input logic signed [15:0] angle,
                               input logic signed [15:0] rate);
    int            err;
    int            integ;
    longint        acc;
    longint        drive;
    drive_result_t res;
    err   = int'(angle) - setpoint_copy;
    integ = integral_copy + err;
    if (integ <= -IntegBound) integ = -IntegBound;
    else if (integ >= IntegBound) integ = IntegBound;
    integral_copy = integ;
    acc = longint'(kp_copy) * err + longint'(ki_copy) * integ
        + (longint'(int'(rate)) * kd_copy) / RateDivisor;
    drive = acc / Q16One;
    res.clamped = 1'b0;
    if (drive > DriveBound) begin
      drive = DriveBound;
      res.clamped = 1'b1;
    end else if (drive < -DriveBound) begin
      drive = -DriveBound;
      res.clamped = 1'b1;
    end
    res.drive = drive[14:0];
    expected_drives.push_back(res);
  endtask

  // Sender: bursts of random length separated by random gaps
  int      burst_left = 1;
  int      gap_left   = 0;
  sample_t next_sample;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_drive(measured_angle, rate_sample);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          next_sample = pending_samples.pop_front();
          in_valid       <= 1'b1;
          measured_angle <= next_sample.angle;
          rate_sample    <= next_sample.rate;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction; stalls on its own pattern
  int            hold_left  = 0;
  int            stall_left = 0;
  int            stall_mode = 0;
  int            stall_tick = 0;
  logic          ready_next;
  drive_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drives.size() == 0) begin
          report_mismatch("unexpected result, drive_value", 0, int'(drive_value));
        end else begin
          want = expected_drives.pop_front();
          if (drive_value !== want.drive)
            report_mismatch("drive_value", int'($signed(want.drive)), int'(drive_value));
          if (drive_clamped !== want.clamped)
            report_mismatch("drive_clamped", int'(want.clamped), int'(drive_clamped));
        end
        results_seen++;
        // long hold-off lets the pipeline fill and push back on the sender
        if (results_seen == 200 || results_seen == 460) hold_left = HoldCycles;
      end
      stall_tick++;
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        if (stall_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_left = $urandom_range(10, 60);
        end else begin
          stall_left--;
        end
        case (stall_mode)
          0: ready_next = 1'b1;
          1: ready_next = ($urandom_range(0, 1) == 1);
          2: ready_next = (stall_tick % 3 != 0);
          default: ready_next = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_ready <= ready_next;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[15:0];
    case (idx)
      apid_pkg::REG_SETPOINT: setpoint_copy = int'($signed(value[15:0]));
      apid_pkg::REG_GAIN_P:   kp_copy       = int'($signed(value[15:0]));
      apid_pkg::REG_GAIN_I:   ki_copy       = int'($signed(value[15:0]));
      apid_pkg::REG_GAIN_D:   kd_copy       = int'($signed(value[15:0]));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input int setpoint, input int kp, input int ki, input int kd);
    write_reg(apid_pkg::REG_SETPOINT, setpoint);
    write_reg(apid_pkg::REG_GAIN_P, kp);
    write_reg(apid_pkg::REG_GAIN_I, ki);
    write_reg(apid_pkg::REG_GAIN_D, kd);
    @(negedge clk);
  endtask

  task automatic queue_sample(input int angle, input int rate);
    sample_t s;
    s.angle = angle[15:0];
    s.rate  = rate[15:0];
    pending_samples.push_back(s);
  endtask

  // Every sample sent, every result checked, pipeline given time to settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_drives.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic int rand_q88();
    int pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0: return -32768;
      1: return 32767;
      2: return 0;
      3, 4: return $urandom_range(0, 4096);
      5: return -int'($urandom_range(0, 4096));
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  function automatic int clip16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic queue_random_set();
    int angle;
    int rate;
    int pick;
    repeat (ItemsPerSet) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        // small error around the setpoint moves the integral in small steps
        angle = clip16(setpoint_copy + int'($urandom_range(0, 1024)) - 512);
        rate  = int'($urandom_range(0, 2048)) - 1024;
      end else if (pick < 7) begin
        angle = int'($signed(16'($urandom())));
        rate  = int'($signed(16'($urandom())));
      end else begin
        angle = clip16(setpoint_copy + int'($urandom_range(0, 16384)) - 8192);
        rate  = int'($signed(16'($urandom())));
      end
      queue_sample(angle, rate);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset gains: output stays zero while the integral hits its upper limit
    queue_sample(32767, -32768);
    queue_sample(-32768, 32767);
    queue_sample(0, 0);
    wait_idle();

    // Output limit, positive side: exactly 9000, truncated to 9000, then over
    write_all(-32768, 16384, 0, 0);
    queue_sample(3232, 5);
    queue_sample(3233, -5);
    queue_sample(3236, 32767);
    queue_sample(32767, -32768);
    queue_sample(-32768, 0);
    wait_idle();

    // Output limit, negative side, with truncation toward zero
    write_all(32767, 16384, 0, 0);
    queue_sample(-3233, 1);
    queue_sample(-3236, -1);
    queue_sample(-3237, 0);
    queue_sample(-32768, 100);
    wait_idle();

    // Integral limit in both directions
    write_all(0, 0, 32767, 0);
    queue_sample(32767, 0);
    queue_sample(32767, 0);
    queue_sample(-32768, 0);
    queue_sample(-32768, 0);
    queue_sample(-32768, 0);
    queue_sample(100, 0);
    wait_idle();

    // Rate term alone, division by ten truncating toward zero
    write_all(-1, 0, 0, -32768);
    queue_sample(-1, -32768);
    queue_sample(-1, 32767);
    queue_sample(-1, 7);
    queue_sample(-1, -7);
    wait_idle();

    // Random samples over several register settings, extremes first
    write_all(32767, 32767, 32767, 32767);
    queue_random_set();
    wait_idle();
    write_all(-32768, -32768, -32768, -32768);
    queue_random_set();
    wait_idle();
    repeat (4) begin
      write_all(rand_q88(), rand_q88(), rand_q88(), rand_q88());
      queue_random_set();
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/apid_pkg.sv
sv/apid_integ.sv
sv/apid_mac.sv
sv/apid_out.sv
sv/angle_pid_saturating_top.sv
sv/apid_checker.sv
dv/angle_pid_saturating_top_test.sv
